// ===== hdl/hsss_pkg.sv =====
// Package for the hash seed score search block: sizes, codes, command and
// configuration types, and the one-at-a-time hash round functions.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package hsss_pkg;

	localparam int MAX_KEYS    = 32;
	localparam int MAX_PAIRS   = 64;
	localparam int MAX_ITEMS   = (MAX_PAIRS > MAX_KEYS) ? MAX_PAIRS : MAX_KEYS;
	localparam int KEY_AW      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int PAIR_AW     = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
	localparam int ACC_W       = $clog2(2 * MAX_PAIRS + 1);
	localparam int SUM_W       = $clog2(2 * MAX_KEYS * MAX_PAIRS + 1);

	localparam int HASH_W      = 30;
	localparam int SLOT_W      = 6;
	localparam int SCORE_W     = 13;
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	localparam int KEY_COUNT_W  = 6;
	localparam int PAIR_COUNT_W = 7;
	localparam int CFG_DATA_W   = 7;
	localparam int CFG_INDEX_W  = 1;
	localparam logic [CFG_INDEX_W-1:0]  REG_KEY_COUNT    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0]  REG_PAIR_COUNT   = 1'b1;
	localparam logic [KEY_COUNT_W-1:0]  KEY_COUNT_RESET  = 6'd17;
	localparam logic [PAIR_COUNT_W-1:0] PAIR_COUNT_RESET = 7'd48;

	localparam logic [1:0] OP_LOAD_KEY  = 2'd0;
	localparam logic [1:0] OP_LOAD_PAIR = 2'd1;
	localparam logic [1:0] OP_SCORE     = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_KEY   = 2'd0,
		CMD_PAIR  = 2'd1,
		CMD_SCORE = 2'd2
	} cmd_kind_t;

	// For a score command the seed sits in data[31:0]; a pair keeps the low
	// probe in data[31:0] and the high probe in data[63:32].
	typedef struct packed {
		cmd_kind_t          kind;
		logic [SLOT_W-1:0]  slot;
		logic [63:0]        data;
		logic               start;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] keys;
		logic [CNT_W-1:0] pairs;
	} cfg_t;

	function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t1;
		logic [31:0] t2;
		t1 = h + {24'b0, b};
		t2 = t1 + (t1 << 10);
		return t2 ^ (t2 >> 6);
	endfunction

	function automatic logic [HASH_W-1:0] oaat_final(input logic [31:0] h);
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		t1 = h + (h << 3);
		t2 = t1 ^ (t1 >> 11);
		t3 = t2 + (t2 << 15);
		return t3[HASH_W-1:0];
	endfunction

endpackage

// ===== hdl/hash_seed_score_search.sv =====
// Top level of the hash seed score search block: configuration registers,
// front part with its command queue, and back part.
// Depends on hsss_pkg, hsss_front and hsss_back.
//
//   Channel    Signals                                        Handshake
//   command    operation, slot, key_bytes, probe_low_bytes,   start & !busy
//              probe_high_bytes, seed_value, start_search
//   config     wr_index, wr_data                              wr_en
//   result     seed_score, best_seed_so_far, best_score_so_far   done, one cycle
//
// A load transaction passes through the four-entry queue and is written into
// its table when the back part is idle and takes it from the queue.
// In a score transaction one key, then one probe pair, enters the hash
// pipelines per cycle, and the key cell accumulators are summed one per
// cycle. Reset clears the queue and the running best and restores the
// counts; table contents stay undefined until loaded. busy rises only when
// the queue is full; results cannot be held off.
`timescale 1ns / 1ps

module hash_seed_score_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [hsss_pkg::SLOT_W-1:0]       slot,
	input  logic [31:0]                       key_bytes,
	input  logic [31:0]                       probe_low_bytes,
	input  logic [31:0]                       probe_high_bytes,
	input  logic [31:0]                       seed_value,
	input  logic                              start_search,
	input  logic                              wr_en,
	input  logic [hsss_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [hsss_pkg::CFG_DATA_W-1:0]   wr_data,
	output logic                              done,
	output logic [hsss_pkg::SCORE_W-1:0]      seed_score,
	output logic [31:0]                       best_seed_so_far,
	output logic [hsss_pkg::SCORE_W-1:0]      best_score_so_far
);

	logic [hsss_pkg::KEY_COUNT_W-1:0]  key_count_q;
	logic [hsss_pkg::PAIR_COUNT_W-1:0] pair_count_q;
	hsss_pkg::cfg_t                    cfg;
	logic                              cmd_valid;
	hsss_pkg::cmd_t                    cmd;
	logic                              cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= hsss_pkg::KEY_COUNT_RESET;
			pair_count_q <= hsss_pkg::PAIR_COUNT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				hsss_pkg::REG_KEY_COUNT:  key_count_q  <= wr_data[hsss_pkg::KEY_COUNT_W-1:0];
				hsss_pkg::REG_PAIR_COUNT: pair_count_q <= wr_data[hsss_pkg::PAIR_COUNT_W-1:0];
				default: begin
					key_count_q  <= key_count_q;
				end
			endcase
		end
	end

	always_comb begin
		cfg.keys  = ({26'b0, key_count_q} > hsss_pkg::MAX_KEYS) ?
			hsss_pkg::CNT_W'(hsss_pkg::MAX_KEYS) : hsss_pkg::CNT_W'(key_count_q);
		cfg.pairs = ({25'b0, pair_count_q} > hsss_pkg::MAX_PAIRS) ?
			hsss_pkg::CNT_W'(hsss_pkg::MAX_PAIRS) : hsss_pkg::CNT_W'(pair_count_q);
	end

	hsss_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.slot             (slot),
		.key_bytes        (key_bytes),
		.probe_low_bytes  (probe_low_bytes),
		.probe_high_bytes (probe_high_bytes),
		.seed_value       (seed_value),
		.start_search     (start_search),
		.cmd_valid        (cmd_valid),
		.cmd              (cmd),
		.cmd_pop          (cmd_pop)
	);

	hsss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.done       (done),
		.seed_score (seed_score),
		.lead_seed  (best_seed_so_far),
		.best_score (best_score_so_far)
	);

endmodule

// ===== hdl/hsss_front.sv =====
// Front part of the hash seed score search block: accepts commands, drops
// those that do nothing, and queues the rest for the back part.
// Depends on hsss_pkg.
`timescale 1ns / 1ps

module hsss_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [hsss_pkg::SLOT_W-1:0] slot,
	input  logic [31:0]               key_bytes,
	input  logic [31:0]               probe_low_bytes,
	input  logic [31:0]               probe_high_bytes,
	input  logic [31:0]               seed_value,
	input  logic                      start_search,
	output logic                      cmd_valid,
	output hsss_pkg::cmd_t            cmd,
	input  logic                      cmd_pop
);

	hsss_pkg::cmd_t                    cmd_in;
	logic                              keep;
	logic                              push;
	hsss_pkg::cmd_t                    queue_q [hsss_pkg::QUEUE_DEPTH];
	logic [hsss_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [hsss_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [hsss_pkg::QUEUE_CW-1:0]     count_q;

	always_comb begin
		cmd_in.kind  = hsss_pkg::CMD_SCORE;
		cmd_in.slot  = slot;
		cmd_in.data  = {32'b0, seed_value};
		cmd_in.start = start_search;
		keep         = 1'b0;
		case (operation)
			hsss_pkg::OP_LOAD_KEY: begin
				cmd_in.kind = hsss_pkg::CMD_KEY;
				cmd_in.data = {32'b0, key_bytes};
				keep        = ({26'b0, slot} < hsss_pkg::MAX_KEYS);
			end
			hsss_pkg::OP_LOAD_PAIR: begin
				cmd_in.kind = hsss_pkg::CMD_PAIR;
				cmd_in.data = {probe_high_bytes, probe_low_bytes};
				keep        = ({26'b0, slot} < hsss_pkg::MAX_PAIRS);
			end
			hsss_pkg::OP_SCORE: begin
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign busy      = (count_q == hsss_pkg::QUEUE_CW'(hsss_pkg::QUEUE_DEPTH));
	assign push      = start && !busy && keep;
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, cmd_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// ===== hdl/hsss_hash.sv =====
// Five-stage pipeline for the seeded one-at-a-time hash of four bytes:
// one byte round per stage, then the avalanche steps and the 30-bit mask.
// Depends on hsss_pkg.
`timescale 1ns / 1ps

module hsss_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [31:0]                 in_bytes,
	input  logic [31:0]                 in_seed,
	output logic                        out_valid,
	output logic [hsss_pkg::HASH_W-1:0] out_hash
);

	logic                        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0]                 h_s1, h_s2, h_s3, h_s4;
	logic [31:0]                 bytes_s1, bytes_s2, bytes_s3;
	logic [hsss_pkg::HASH_W-1:0] hash_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		h_s1     <= hsss_pkg::oaat_round(in_seed, in_bytes[7:0]);
		bytes_s1 <= in_bytes;
		h_s2     <= hsss_pkg::oaat_round(h_s1, bytes_s1[15:8]);
		bytes_s2 <= bytes_s1;
		h_s3     <= hsss_pkg::oaat_round(h_s2, bytes_s2[23:16]);
		bytes_s3 <= bytes_s2;
		h_s4     <= hsss_pkg::oaat_round(h_s3, bytes_s3[31:24]);
		hash_s5  <= hsss_pkg::oaat_final(h_s4);
	end

	assign out_valid = v_s5;
	assign out_hash  = hash_s5;

endmodule

// ===== hdl/hsss_back.sv =====
// Back part of the hash seed score search block: key and pair tables, the
// two hash pipelines, the chain of key cells and the running best.
// Depends on hsss_pkg and hsss_hash.
`timescale 1ns / 1ps

module hsss_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hsss_pkg::cfg_t               cfg,
	input  logic                         cmd_valid,
	input  hsss_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	output logic                         done,
	output logic [hsss_pkg::SCORE_W-1:0] seed_score,
	output logic [31:0]                  lead_seed,
	output logic [hsss_pkg::SCORE_W-1:0] best_score
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_KEYS  = 5'b00010,
		S_PAIRS = 5'b00100,
		S_SUM   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [hsss_pkg::CNT_W-1:0]      issue_cnt_q;
	logic [hsss_pkg::CNT_W-1:0]      rx_cnt_q;
	logic [31:0]                     seed_q;

	logic [31:0]                     key_mem  [hsss_pkg::MAX_KEYS];
	logic [63:0]                     pair_mem [hsss_pkg::MAX_PAIRS];
	logic [31:0]                     key_rd_data_s1;
	logic [63:0]                     pair_rd_data_s1;
	logic                            key_rd_valid_s1;
	logic                            pair_rd_valid_s1;

	logic                            key_issue;
	logic                            pair_issue;
	logic                            score_pop;
	logic                            sum_step;

	logic                            a_in_valid;
	logic [31:0]                     a_in_bytes;
	logic                            a_valid;
	logic [hsss_pkg::HASH_W-1:0]     a_hash;
	logic                            b_valid;
	logic [hsss_pkg::HASH_W-1:0]     b_hash;

	logic [hsss_pkg::HASH_W-1:0]     kh_q  [hsss_pkg::MAX_KEYS];
	logic [hsss_pkg::ACC_W-1:0]      acc_q [hsss_pkg::MAX_KEYS];
	logic [hsss_pkg::MAX_KEYS-1:0]   act_q;
	logic [hsss_pkg::SUM_W-1:0]      total_q;

	logic [hsss_pkg::SCORE_W-1:0]    score_w;
	logic [hsss_pkg::SCORE_W-1:0]    score_q;
	logic [31:0]                     lead_seed_q;
	logic [hsss_pkg::SCORE_W-1:0]    best_score_q;
	logic                            done_q;

	assign cmd_pop    = (state_q == S_IDLE) && cmd_valid;
	assign score_pop  = cmd_pop && (cmd.kind == hsss_pkg::CMD_SCORE);
	assign key_issue  = (state_q == S_KEYS) && (issue_cnt_q < cfg.keys);
	assign pair_issue = (state_q == S_PAIRS) && (issue_cnt_q < cfg.pairs);
	assign sum_step   = (state_q == S_SUM) &&
		(issue_cnt_q != hsss_pkg::CNT_W'(hsss_pkg::MAX_KEYS));

	assign score_w = (total_q > hsss_pkg::SUM_W'(hsss_pkg::SCORE_MAX)) ?
		hsss_pkg::SCORE_MAX : hsss_pkg::SCORE_W'(total_q);

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == hsss_pkg::CMD_KEY)) begin
			key_mem[hsss_pkg::KEY_AW'(cmd.slot)] <= cmd.data[31:0];
		end
		if (key_issue) begin
			key_rd_data_s1 <= key_mem[issue_cnt_q[hsss_pkg::KEY_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == hsss_pkg::CMD_PAIR)) begin
			pair_mem[hsss_pkg::PAIR_AW'(cmd.slot)] <= cmd.data;
		end
		if (pair_issue) begin
			pair_rd_data_s1 <= pair_mem[issue_cnt_q[hsss_pkg::PAIR_AW-1:0]];
		end
	end

	assign a_in_valid = key_rd_valid_s1 || pair_rd_valid_s1;
	assign a_in_bytes = key_rd_valid_s1 ? key_rd_data_s1 : pair_rd_data_s1[31:0];

	hsss_hash u_hash_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_in_valid),
		.in_bytes  (a_in_bytes),
		.in_seed   (seed_q),
		.out_valid (a_valid),
		.out_hash  (a_hash)
	);

	hsss_hash u_hash_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pair_rd_valid_s1),
		.in_bytes  (pair_rd_data_s1[63:32]),
		.in_seed   (seed_q),
		.out_valid (b_valid),
		.out_hash  (b_hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			issue_cnt_q      <= '0;
			rx_cnt_q         <= '0;
			key_rd_valid_s1  <= 1'b0;
			pair_rd_valid_s1 <= 1'b0;
			lead_seed_q      <= '0;
			best_score_q     <= '0;
			score_q          <= '0;
			done_q           <= 1'b0;
		end else begin
			key_rd_valid_s1  <= key_issue;
			pair_rd_valid_s1 <= pair_issue;
			done_q           <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (score_pop) begin
						issue_cnt_q <= '0;
						rx_cnt_q    <= '0;
						state_q     <= S_KEYS;
						if (cmd.start) begin
							lead_seed_q  <= '0;
							best_score_q <= '0;
						end
					end
				end
				S_KEYS: begin
					if (rx_cnt_q == cfg.keys) begin
						issue_cnt_q <= '0;
						rx_cnt_q    <= '0;
						state_q     <= S_PAIRS;
					end else begin
						if (key_issue) begin
							issue_cnt_q <= issue_cnt_q + 1'b1;
						end
						if (a_valid) begin
							rx_cnt_q <= rx_cnt_q + 1'b1;
						end
					end
				end
				S_PAIRS: begin
					if (rx_cnt_q == cfg.pairs) begin
						issue_cnt_q <= '0;
						state_q     <= S_SUM;
					end else begin
						if (pair_issue) begin
							issue_cnt_q <= issue_cnt_q + 1'b1;
						end
						if (b_valid) begin
							rx_cnt_q <= rx_cnt_q + 1'b1;
						end
					end
				end
				S_SUM: begin
					if (sum_step) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					score_q <= score_w;
					if (score_w > best_score_q) begin
						best_score_q <= score_w;
						lead_seed_q  <= seed_q;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= '0;
		end else if (score_pop) begin
			act_q <= '0;
		end else if ((state_q == S_KEYS) && a_valid) begin
			for (int i = 0; i < hsss_pkg::MAX_KEYS; i++) begin
				if (i == hsss_pkg::MAX_KEYS - 1) begin
					act_q[i] <= 1'b1;
				end else begin
					act_q[i] <= act_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (score_pop) begin
			seed_q  <= cmd.data[31:0];
			total_q <= '0;
			for (int i = 0; i < hsss_pkg::MAX_KEYS; i++) begin
				acc_q[i] <= '0;
			end
		end else if ((state_q == S_KEYS) && a_valid) begin
			for (int i = 0; i < hsss_pkg::MAX_KEYS; i++) begin
				if (i == hsss_pkg::MAX_KEYS - 1) begin
					kh_q[i] <= a_hash;
				end else begin
					kh_q[i] <= kh_q[i+1];
				end
			end
		end else if ((state_q == S_PAIRS) && b_valid) begin
			for (int i = 0; i < hsss_pkg::MAX_KEYS; i++) begin
				if (act_q[i]) begin
					acc_q[i] <= acc_q[i]
						+ hsss_pkg::ACC_W'(a_hash < kh_q[i])
						+ hsss_pkg::ACC_W'(kh_q[i] <= b_hash);
				end
			end
		end else if (sum_step) begin
			total_q <= total_q + hsss_pkg::SUM_W'(acc_q[0]);
			for (int i = 0; i < hsss_pkg::MAX_KEYS; i++) begin
				if (i == hsss_pkg::MAX_KEYS - 1) begin
					acc_q[i] <= '0;
				end else begin
					acc_q[i] <= acc_q[i+1];
				end
			end
		end
	end

	assign done       = done_q;
	assign seed_score = score_q;
	assign lead_seed  = lead_seed_q;
	assign best_score = best_score_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe lasted more than one cycle");

	a_done_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_DONE))
		else $error("result strobe without a completed score");

	a_pair_hashes_paired: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid |-> a_valid)
		else $error("high probe hash arrived without its low probe hash");

	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> (best_score_q >= $past(best_score_q)))
		else $error("running best score fell outside a start transaction");

endmodule
